/* hdl/tlq_pkg.sv */
`timescale 1ns / 1ps
// shared constants for the thick line quad setup pipeline
// no dependencies

package tlq_pkg;

	// default coordinate width, signed Q12.4
	localparam int COORD_WIDTH_DEF = 16;

	// line thickness register, unsigned Q8.4
	localparam int THICK_WIDTH = 12;
	localparam logic [THICK_WIDTH-1:0] THICK_RESET = 12'd16;

	// extra fraction bits carried by a length
	localparam int GUARD_BITS = 8;

	// a scaled component never exceeds half the thickness, rounded
	localparam int QUOT_WIDTH = THICK_WIDTH;

endpackage

/* hdl/tlq_sqrt_pipe.sv */
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage
// depends on: nothing; the caller's request data rides along as a side vector

module tlq_sqrt_pipe #(
	parameter int NW = 49,
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [NW-1:0]         in_rad,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output logic [(NW+1)/2-1:0]   out_root,
	output logic [SW-1:0]         out_side
);
	localparam int RW  = (NW + 1) / 2;
	localparam int NP  = 2 * RW;
	localparam int RMW = RW + 2;

	logic           v_s    [RW+1];
	logic [RMW-1:0] rem_s  [RW+1];
	logic [RW-1:0]  root_s [RW+1];
	logic [NP-1:0]  rad_s  [RW+1];
	logic [SW-1:0]  side_s [RW+1];

	// stage zero is the incoming request
	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = NP'(in_rad);
	assign side_s[0] = in_side;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RMW+1:0] cat;
		logic [RMW+1:0] sub;
		logic [RMW+2:0] diff;
		logic           neg;

		// trial subtract of 4*root+1 from the remainder with the next bit pair
		assign cat  = {rem_s[k], rad_s[k][NP-1 -: 2]};
		assign sub  = {RMW'(root_s[k]), 2'b01};
		assign diff = {1'b0, cat} - {1'b0, sub};
		assign neg  = diff[RMW+2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= neg ? cat[RMW-1:0] : diff[RMW-1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ~neg};
				rad_s[k+1]  <= {rad_s[k][NP-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

/* hdl/tlq_div_pipe.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, two numerators over one shared divisor
// depends on: nothing; one quotient bit per stage, side vector rides along

module tlq_div_pipe #(
	parameter int NW = 37,
	parameter int DW = 26,
	parameter int QW = 12,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num_a,
	input  logic [NW-1:0] in_num_b,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_q_a,
	output logic [QW-1:0] out_q_b,
	output logic [SW-1:0] out_side
);
	localparam int XW = ((NW > DW + QW - 1) ? NW : DW + QW - 1) + 1;

	logic          v_s    [QW+1];
	logic [XW-1:0] pa_s   [QW+1];
	logic [XW-1:0] pb_s   [QW+1];
	logic [QW-1:0] qa_s   [QW+1];
	logic [QW-1:0] qb_s   [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign v_s[0]    = in_valid;
	assign pa_s[0]   = XW'(in_num_a);
	assign pb_s[0]   = XW'(in_num_b);
	assign qa_s[0]   = '0;
	assign qb_s[0]   = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [XW-1:0] dsh;
		logic [XW:0]   ta;
		logic [XW:0]   tb;

		// compare each partial numerator against the divisor at this bit weight
		assign dsh = XW'(den_s[k]) << (QW - 1 - k);
		assign ta  = {1'b0, pa_s[k]} - {1'b0, dsh};
		assign tb  = {1'b0, pb_s[k]} - {1'b0, dsh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s[k+1]   <= ta[XW] ? pa_s[k] : ta[XW-1:0];
				pb_s[k+1]   <= tb[XW] ? pb_s[k] : tb[XW-1:0];
				qa_s[k+1]   <= {qa_s[k][QW-2:0], ~ta[XW]};
				qb_s[k+1]   <= {qb_s[k][QW-2:0], ~tb[XW]};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign out_q_a   = qa_s[QW];
	assign out_q_b   = qb_s[QW];
	assign out_side  = side_s[QW];

endmodule

/* hdl/tlq_vec_scale.sv */
`timescale 1ns / 1ps
// scales a vector (a, b) to length thickness/2: round(a*T/(2|v|)), round(b*T/(2|v|))
// depends on: tlq_pkg, tlq_sqrt_pipe, tlq_div_pipe

module tlq_vec_scale #(
	parameter int CW = tlq_pkg::COORD_WIDTH_DEF,
	parameter int SW = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [CW:0]                in_a,
	input  logic signed [CW:0]                in_b,
	input  logic [SW-1:0]                     in_side,
	input  logic [tlq_pkg::THICK_WIDTH-1:0]   thick,
	output logic                              out_valid,
	output logic signed [tlq_pkg::QUOT_WIDTH:0] out_qa,
	output logic signed [tlq_pkg::QUOT_WIDTH:0] out_qb,
	output logic                              out_zero,
	output logic [SW-1:0]                     out_side
);
	import tlq_pkg::*;

	localparam int MW   = CW;
	localparam int SQW  = 2 * MW + 1;
	localparam int NW   = SQW + 2 * GUARD_BITS;
	localparam int RW   = (NW + 1) / 2;
	localparam int NUMW = MW + THICK_WIDTH;
	localparam int PW   = NUMW + GUARD_BITS + 1;
	localparam int DW   = RW + 1;
	localparam int QW   = QUOT_WIDTH;

	typedef struct packed {
		logic [SW-1:0]   side;
		logic            neg_a;
		logic            neg_b;
		logic [NUMW-1:0] num_a;
		logic [NUMW-1:0] num_b;
		logic            zero;
	} sq_side_t;

	typedef struct packed {
		logic [SW-1:0] side;
		logic          neg_a;
		logic          neg_b;
		logic          zero;
	} dv_side_t;

	// stage 1: magnitudes and signs
	logic          v_s1;
	logic [MW-1:0] mag_a_s1, mag_b_s1;
	logic          neg_a_s1, neg_b_s1;
	logic [SW-1:0] side_s1;

	// stage 2: squares and numerators
	logic            v_s2;
	logic [2*MW-1:0] sq_a_s2, sq_b_s2;
	logic [NUMW-1:0] num_a_s2, num_b_s2;
	logic            neg_a_s2, neg_b_s2;
	logic [SW-1:0]   side_s2;

	// stage 3: squared length
	logic            v_s3;
	logic [SQW-1:0]  sum_s3;
	logic            zero_s3;
	logic [NUMW-1:0] num_a_s3, num_b_s3;
	logic            neg_a_s3, neg_b_s3;
	logic [SW-1:0]   side_s3;

	sq_side_t       sq_in, sq_out;
	logic           sq_valid;
	logic [RW-1:0]  sq_root;

	// stage 4: rounded numerators and doubled length
	logic          v_s4;
	logic [PW-1:0] na_s4, nb_s4;
	logic [DW-1:0] den_s4;
	dv_side_t      dv_s4;

	dv_side_t      dv_out;
	logic          dv_valid;
	logic [QW-1:0] dv_qa, dv_qb;

	// stage 5: signed result
	logic                v_s5;
	logic signed [QW:0]  qa_s5, qb_s5;
	logic                zero_s5;
	logic [SW-1:0]       side_s5;

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_valid;
			v_s5 <= dv_valid;
		end
	end

	// front: abs, multiply, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			mag_a_s1 <= in_a[CW] ? MW'(-in_a) : MW'(in_a);
			mag_b_s1 <= in_b[CW] ? MW'(-in_b) : MW'(in_b);
			neg_a_s1 <= in_a[CW];
			neg_b_s1 <= in_b[CW];
			side_s1  <= in_side;

			sq_a_s2  <= (2*MW)'(mag_a_s1) * (2*MW)'(mag_a_s1);
			sq_b_s2  <= (2*MW)'(mag_b_s1) * (2*MW)'(mag_b_s1);
			num_a_s2 <= NUMW'(mag_a_s1) * NUMW'(thick);
			num_b_s2 <= NUMW'(mag_b_s1) * NUMW'(thick);
			neg_a_s2 <= neg_a_s1;
			neg_b_s2 <= neg_b_s1;
			side_s2  <= side_s1;

			sum_s3   <= SQW'(sq_a_s2) + SQW'(sq_b_s2);
			zero_s3  <= (sq_a_s2 == '0) && (sq_b_s2 == '0);
			num_a_s3 <= num_a_s2;
			num_b_s3 <= num_b_s2;
			neg_a_s3 <= neg_a_s2;
			neg_b_s3 <= neg_b_s2;
			side_s3  <= side_s2;
		end
	end

	// length with guard bits
	assign sq_in.side  = side_s3;
	assign sq_in.neg_a = neg_a_s3;
	assign sq_in.neg_b = neg_b_s3;
	assign sq_in.num_a = num_a_s3;
	assign sq_in.num_b = num_b_s3;
	assign sq_in.zero  = zero_s3;

	tlq_sqrt_pipe #(
		.NW (NW),
		.SW ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_rad    ({sum_s3, {(2*GUARD_BITS){1'b0}}}),
		.in_side   (sq_in),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_out)
	);

	// add half the divisor for round to nearest
	always_ff @(posedge clk) begin
		if (en) begin
			na_s4       <= PW'({sq_out.num_a, {GUARD_BITS{1'b0}}}) + PW'(sq_root);
			nb_s4       <= PW'({sq_out.num_b, {GUARD_BITS{1'b0}}}) + PW'(sq_root);
			den_s4      <= {sq_root, 1'b0};
			dv_s4.side  <= sq_out.side;
			dv_s4.neg_a <= sq_out.neg_a;
			dv_s4.neg_b <= sq_out.neg_b;
			dv_s4.zero  <= sq_out.zero;
		end
	end

	tlq_div_pipe #(
		.NW (PW),
		.DW (DW),
		.QW (QW),
		.SW ($bits(dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num_a  (na_s4),
		.in_num_b  (nb_s4),
		.in_den    (den_s4),
		.in_side   (dv_s4),
		.out_valid (dv_valid),
		.out_q_a   (dv_qa),
		.out_q_b   (dv_qb),
		.out_side  (dv_out)
	);

	// restore sign, zero length gives no offset
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_out.zero) begin
				qa_s5 <= '0;
				qb_s5 <= '0;
			end else begin
				qa_s5 <= dv_out.neg_a ? -$signed({1'b0, dv_qa}) : $signed({1'b0, dv_qa});
				qb_s5 <= dv_out.neg_b ? -$signed({1'b0, dv_qb}) : $signed({1'b0, dv_qb});
			end
			zero_s5 <= dv_out.zero;
			side_s5 <= dv_out.side;
		end
	end

	assign out_valid = v_s5;
	assign out_qa    = qa_s5;
	assign out_qb    = qb_s5;
	assign out_zero  = zero_s5;
	assign out_side  = side_s5;

endmodule

/* hdl/thick_line_quad_setup.sv */
`timescale 1ns / 1ps
// path from request to result: two length/scale units in series, each a square root
// of one bit per stage followed by a divider of one quotient bit per stage
// throughput: one segment per cycle; input stalls only while the output buffer is full
// reset: arst_n clears all valid bits and the buffer, thickness returns to 1.0
// depends on: tlq_pkg, tlq_vec_scale

module thick_line_quad_setup #(
	parameter int COORD_WIDTH = tlq_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tlq_pkg::THICK_WIDTH-1:0] cfg_data,
	// segment request
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   start_x,
	input  logic signed [COORD_WIDTH-1:0]   start_y,
	input  logic signed [COORD_WIDTH-1:0]   end_x,
	input  logic signed [COORD_WIDTH-1:0]   end_y,
	input  logic signed [COORD_WIDTH-1:0]   next_x,
	input  logic signed [COORD_WIDTH-1:0]   next_y,
	input  logic                            has_next,
	// quad result
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [COORD_WIDTH-1:0]   corner_a_x,
	output logic signed [COORD_WIDTH-1:0]   corner_a_y,
	output logic signed [COORD_WIDTH-1:0]   corner_b_x,
	output logic signed [COORD_WIDTH-1:0]   corner_b_y,
	output logic signed [COORD_WIDTH-1:0]   corner_c_x,
	output logic signed [COORD_WIDTH-1:0]   corner_c_y,
	output logic signed [COORD_WIDTH-1:0]   corner_d_x,
	output logic signed [COORD_WIDTH-1:0]   corner_d_y,
	output logic                            degenerate
);
	import tlq_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int QW = QUOT_WIDTH;
	localparam int AW = ((CW > QW + 1) ? CW : QW + 1) + 1;
	localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [1:0] {
		BUF_EMPTY,
		BUF_ONE,
		BUF_FULL
	} buf_state_t;

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic                 has_next;
	} seg_side_t;

	typedef struct packed {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic                 degen;
	} ext_side_t;

	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic                 degen;
	} quad_t;

	// saturating add or subtract of an offset to a coordinate
	function automatic logic signed [CW-1:0] sat_sum(input logic signed [CW-1:0] p,
			input logic signed [QW:0] q, input logic sub);
		logic signed [AW-1:0] s;
		s = sub ? (AW'(p) - AW'(q)) : (AW'(p) + AW'(q));
		if (s > SAT_HI) begin
			return SAT_HI[CW-1:0];
		end else if (s < SAT_LO) begin
			return SAT_LO[CW-1:0];
		end
		return s[CW-1:0];
	endfunction

	logic                  en;
	logic [THICK_WIDTH-1:0] line_thickness_q;

	logic                 v_s1;
	seg_side_t            seg_s1;
	logic signed [CW-1:0] nx_s1, ny_s1;

	logic                 sc1_valid;
	logic signed [QW:0]   sc1_qa, sc1_qb;
	logic                 sc1_zero;
	seg_side_t            sc1_side;

	logic                 v_s2;
	ext_side_t            ext_s2;

	logic                 sc2_valid;
	logic signed [QW:0]   sc2_qa, sc2_qb;
	logic                 sc2_zero;
	ext_side_t            sc2_side;

	logic                 v_s3;
	quad_t                quad_s3;

	quad_t                buf0_q, buf1_q;
	buf_state_t           buf_state_q;
	logic                 pop;

	// whole pipeline advances while the output buffer has room
	assign en        = (buf_state_q != BUF_FULL);
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	// thickness register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_thickness_q <= THICK_RESET;
		end else if (cfg_valid) begin
			line_thickness_q <= cfg_data;
		end
	end

	// valid bits of the top stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= sc1_valid;
			v_s3 <= sc2_valid;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1.sx       <= start_x;
			seg_s1.sy       <= start_y;
			seg_s1.ex       <= end_x;
			seg_s1.ey       <= end_y;
			seg_s1.has_next <= has_next;
			nx_s1           <= next_x;
			ny_s1           <= next_y;
		end
	end

	// extension direction from start to the following point
	tlq_vec_scale #(
		.CW (CW),
		.SW ($bits(seg_side_t))
	) u_scale_ext (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_a      ((CW+1)'(nx_s1) - (CW+1)'(seg_s1.sx)),
		.in_b      ((CW+1)'(ny_s1) - (CW+1)'(seg_s1.sy)),
		.in_side   (seg_s1),
		.thick     (line_thickness_q),
		.out_valid (sc1_valid),
		.out_qa    (sc1_qa),
		.out_qb    (sc1_qb),
		.out_zero  (sc1_zero),
		.out_side  (sc1_side)
	);

	// push the end point forward when a following point exists and its direction is nonzero
	always_ff @(posedge clk) begin
		if (en) begin
			ext_s2.sx    <= sc1_side.sx;
			ext_s2.sy    <= sc1_side.sy;
			ext_s2.degen <= sc1_side.has_next && sc1_zero;
			if (sc1_side.has_next && !sc1_zero) begin
				ext_s2.ex <= sat_sum(sc1_side.ex, sc1_qa, 1'b0);
				ext_s2.ey <= sat_sum(sc1_side.ey, sc1_qb, 1'b0);
			end else begin
				ext_s2.ex <= sc1_side.ex;
				ext_s2.ey <= sc1_side.ey;
			end
		end
	end

	// normal of the adjusted segment: (-(ey-sy), ex-sx)
	tlq_vec_scale #(
		.CW (CW),
		.SW ($bits(ext_side_t))
	) u_scale_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_a      ((CW+1)'(ext_s2.sy) - (CW+1)'(ext_s2.ey)),
		.in_b      ((CW+1)'(ext_s2.ex) - (CW+1)'(ext_s2.sx)),
		.in_side   (ext_s2),
		.thick     (line_thickness_q),
		.out_valid (sc2_valid),
		.out_qa    (sc2_qa),
		.out_qb    (sc2_qb),
		.out_zero  (sc2_zero),
		.out_side  (sc2_side)
	);

	// four corners, offset is already zero for a zero-length segment
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s3.ax    <= sat_sum(sc2_side.sx, sc2_qa, 1'b0);
			quad_s3.ay    <= sat_sum(sc2_side.sy, sc2_qb, 1'b0);
			quad_s3.bx    <= sat_sum(sc2_side.ex, sc2_qa, 1'b0);
			quad_s3.by    <= sat_sum(sc2_side.ey, sc2_qb, 1'b0);
			quad_s3.cx    <= sat_sum(sc2_side.ex, sc2_qa, 1'b1);
			quad_s3.cy    <= sat_sum(sc2_side.ey, sc2_qb, 1'b1);
			quad_s3.dx    <= sat_sum(sc2_side.sx, sc2_qa, 1'b1);
			quad_s3.dy    <= sat_sum(sc2_side.sy, sc2_qb, 1'b1);
			quad_s3.degen <= sc2_side.degen || sc2_zero;
		end
	end

	// two-entry output buffer
	assign pop = (buf_state_q != BUF_EMPTY) && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_state_q <= BUF_EMPTY;
			buf0_q      <= '0;
			buf1_q      <= '0;
		end else begin
			case (buf_state_q)
				BUF_EMPTY: begin
					if (en && v_s3) begin
						buf0_q      <= quad_s3;
						buf_state_q <= BUF_ONE;
					end
				end
				BUF_ONE: begin
					if (en && v_s3) begin
						if (pop) begin
							buf0_q <= quad_s3;
						end else begin
							buf1_q      <= quad_s3;
							buf_state_q <= BUF_FULL;
						end
					end else if (pop) begin
						buf_state_q <= BUF_EMPTY;
					end
				end
				BUF_FULL: begin
					if (pop) begin
						buf0_q      <= buf1_q;
						buf_state_q <= BUF_ONE;
					end
				end
				default: buf_state_q <= BUF_EMPTY;
			endcase
		end
	end

	assign out_valid  = (buf_state_q != BUF_EMPTY);
	assign corner_a_x = buf0_q.ax;
	assign corner_a_y = buf0_q.ay;
	assign corner_b_x = buf0_q.bx;
	assign corner_b_y = buf0_q.by;
	assign corner_c_x = buf0_q.cx;
	assign corner_c_y = buf0_q.cy;
	assign corner_d_x = buf0_q.dx;
	assign corner_d_y = buf0_q.dy;
	assign degenerate = buf0_q.degen;

endmodule
